// ===== hw/rtl/icaf_pkg.sv =====
package icaf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF = 13;
    localparam int MAX_STEPS = 24;
    localparam int WF = 24;
    localparam int CW = 28;
    localparam int BLEND_W = 17;
    localparam int QDEPTH = 2;

    localparam logic [BLEND_W-1:0] BLEND_RESET = 17'd1311;
    localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;

    localparam int PI_W_INT = 52707179;
    localparam logic signed [CW-1:0] GAIN_INV = 28'sd10188014;
    localparam logic signed [CW-1:0] PI_W = 28'sd52707179;
    localparam logic signed [CW-1:0] HALF_PI_W = 28'sd26353589;

    localparam logic [23:0] TAN_SAT_Q = 24'd8388608;
    localparam logic [4:0] SQRT_LAST = 5'd23;
    localparam logic [4:0] DIV_TOP = 5'd22;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [15:0] interval;
        logic zero_vec;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_CINIT,
        ST_CORD,
        ST_TCHK,
        ST_DIV,
        ST_MUL,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MOP_AXX,
        MOP_AYY,
        MOP_AZZ,
        MOP_B,
        MOP_C,
        MOP_BGY,
        MOP_CGZ,
        MOP_CRGY,
        MOP_SRGZ,
        MOP_DTR,
        MOP_DTP,
        MOP_AAR,
        MOP_PRR,
        MOP_AAP,
        MOP_PRP
    } mul_op_t;

    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0: v = 28'sd13176795;
            5'd1: v = 28'sd7778716;
            5'd2: v = 28'sd4110060;
            5'd3: v = 28'sd2086331;
            5'd4: v = 28'sd1047214;
            5'd5: v = 28'sd524117;
            5'd6: v = 28'sd262123;
            5'd7: v = 28'sd131069;
            5'd8: v = 28'sd65536;
            5'd9: v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/icaf_front.sv =====
module icaf_front (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    input  logic signed [15:0] s_gyro_z,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic [15:0] s_interval,
    output logic q_valid,
    input  logic q_ready,
    output icaf_pkg::sample_t q_word
);
    import icaf_pkg::*;

    logic full_reg, full_next;
    sample_t word_reg, word_next;
    logic accept;

    assign s_ready = !full_reg || q_ready;
    assign accept = s_valid && s_ready;
    assign q_valid = full_reg;
    assign q_word = word_reg;

    always_comb begin
        full_next = accept || (full_reg && !q_ready);
        word_next = word_reg;
        if (accept) begin
            word_next.gyro_x = s_gyro_x;
            word_next.gyro_y = s_gyro_y;
            word_next.gyro_z = s_gyro_z;
            word_next.accel_x = s_accel_x;
            word_next.accel_y = s_accel_y;
            word_next.accel_z = s_accel_z;
            word_next.interval = s_interval;
            // An all-zero accelerometer vector gives a zero accelerometer tilt on both axes.
            word_next.zero_vec = (s_accel_x == 16'sd0) && (s_accel_y == 16'sd0)
                && (s_accel_z == 16'sd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

// ===== hw/rtl/icaf_queue.sv =====
module icaf_queue (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  icaf_pkg::sample_t in_word,
    output logic out_valid,
    input  logic out_ready,
    output icaf_pkg::sample_t out_word
);
    import icaf_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CNTW = $clog2(QDEPTH + 1);

    sample_t mem_reg [QDEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic push, pop;

    assign in_ready = count_reg != CNTW'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_word = mem_reg[rd_reg];

    always_comb begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = (wr_reg == PW'(QDEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PW'(QDEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_word;
        end
    end

endmodule

// ===== hw/rtl/icaf_back.sv =====
module icaf_back #(
    parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = icaf_pkg::ANGLE_FRAC_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  icaf_pkg::sample_t q_word,
    input  logic [icaf_pkg::BLEND_W-1:0] blend_weight,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [15:0] m_roll_out,
    output logic signed [15:0] m_pitch_out,
    output logic m_clipped
);
    import icaf_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int ANG_W = ANGLE_FRAC_BITS + 3;
    localparam int SH = WF - ANGLE_FRAC_BITS;
    localparam int PI_F = (PI_W_INT + (1 << (SH - 1))) >> SH;
    localparam int HALF_SH = 1 << (SH - 1);

    state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    mul_op_t op_reg, op_next;
    logic ph_reg, ph_next;
    sample_t smp_reg, smp_next;
    logic [31:0] ax2_reg, ax2_next, ay2_reg, ay2_next;
    logic [47:0] sqv_reg [2];
    logic [47:0] sqv_next [2];
    logic [47:0] sqr_reg [2];
    logic [47:0] sqr_next [2];
    logic signed [CW-1:0] cx_reg [4];
    logic signed [CW-1:0] cx_next [4];
    logic signed [CW-1:0] cy_reg [4];
    logic signed [CW-1:0] cy_next [4];
    logic signed [CW-1:0] cz_reg [4];
    logic signed [CW-1:0] cz_next [4];
    logic [1:0] fold_reg, fold_next;
    logic [CW-1:0] div_reg, div_next;
    logic [43:0] rem_reg, rem_next;
    logic [23:0] q_reg, q_next;
    logic tneg_reg, tneg_next;
    logic signed [33:0] b_reg, b_next, c_reg, c_next;
    logic signed [51:0] rr_reg, rr_next;
    logic signed [43:0] pr_reg, pr_next;
    logic signed [39:0] predr_reg, predr_next, predp_reg, predp_next;
    logic signed [59:0] mixr_reg, mixr_next, mixp_reg, mixp_next;
    logic signed [64:0] prod_reg, prod_next;
    logic clip_reg, clip_next;
    logic signed [ANG_W-1:0] roll_reg, roll_next, pitch_reg, pitch_next;
    logic m_valid_reg, m_valid_next;
    logic signed [15:0] roll_out_reg, roll_out_next, pitch_out_reg, pitch_out_next;
    logic clip_out_reg, clip_out_next;

    logic signed [CW-1:0] sr, cr, sp, cp, acc_r, acc_p;
    logic [CW-1:0] as_v, ac_v;
    logic tsat, tneg_c;
    logic signed [24:0] tanv;
    logic [BLEND_W-1:0] alpha, one_minus;
    logic signed [51:0] rr_half;
    logic signed [43:0] pr_half;
    logic signed [39:0] r24_r, r24_p;
    logic signed [64:0] prod_half;
    logic signed [48:0] prod_rnd;
    logic signed [39:0] mul_a;
    logic signed [24:0] mul_b;
    logic [5:0] sq_sh;
    logic [47:0] sq_bit;
    logic [49:0] div_trial;
    logic signed [CW-1:0] cdx [4];
    logic signed [CW-1:0] cdy [4];
    logic signed [CW-1:0] th_r, th_p;
    logic signed [59:0] mr_half, mp_half;
    logic signed [43:0] mr44, mp44, ar, ap;
    logic signed [31:0] roll_ext, pitch_ext;
    logic out_free;

    assign q_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_roll_out = roll_out_reg;
    assign m_pitch_out = pitch_out_reg;
    assign m_clipped = clip_out_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        sr = fold_reg[0] ? -cy_reg[2] : cy_reg[2];
        cr = fold_reg[0] ? -cx_reg[2] : cx_reg[2];
        sp = fold_reg[1] ? -cy_reg[3] : cy_reg[3];
        cp = fold_reg[1] ? -cx_reg[3] : cx_reg[3];
        acc_p = smp_reg.zero_vec ? '0 : cz_reg[0];
        acc_r = smp_reg.zero_vec ? '0 : cz_reg[1];
        as_v = sp[CW-1] ? CW'(-sp) : CW'(sp);
        ac_v = cp[CW-1] ? CW'(-cp) : CW'(cp);
        tsat = {7'b0, as_v} >= {ac_v, 7'b0};
        tneg_c = (cp == '0) ? sp[CW-1] : (sp[CW-1] ^ cp[CW-1]);
        tanv = tneg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        alpha = (blend_weight > BLEND_ONE) ? BLEND_ONE : blend_weight;
        one_minus = BLEND_ONE - alpha;
        rr_half = rr_reg + 52'sd2048;
        r24_r = $signed(rr_half[51:12]);
        pr_half = pr_reg + 44'sd2048;
        r24_p = 40'($signed(pr_half[43:12]));
        prod_half = prod_reg + 65'sd32768;
        prod_rnd = $signed(prod_half[64:16]);
        sq_sh = 6'd46 - {cnt_reg, 1'b0};
        sq_bit = 48'd1 << sq_sh;
        div_trial = 50'(div_reg) << cnt_reg;
        for (int l = 0; l < 4; l++) begin
            cdx[l] = cy_reg[l] >>> cnt_reg;
            cdy[l] = cx_reg[l] >>> cnt_reg;
        end
        th_r = CW'(roll_reg) <<< SH;
        th_p = CW'(pitch_reg) <<< SH;
        mr_half = mixr_reg + 60'sd32768;
        mp_half = mixp_reg + 60'sd32768;
        mr44 = $signed(mr_half[59:16]);
        mp44 = $signed(mp_half[59:16]);
        ar = (mr44 + 44'(HALF_SH)) >>> SH;
        ap = (mp44 + 44'(HALF_SH)) >>> SH;
        roll_ext = 32'(roll_reg);
        pitch_ext = 32'(pitch_reg);
    end

    always_comb begin
        case (op_reg)
            MOP_AXX: begin
                mul_a = 40'(smp_reg.accel_x);
                mul_b = 25'(smp_reg.accel_x);
            end
            MOP_AYY: begin
                mul_a = 40'(smp_reg.accel_y);
                mul_b = 25'(smp_reg.accel_y);
            end
            MOP_AZZ: begin
                mul_a = 40'(smp_reg.accel_z);
                mul_b = 25'(smp_reg.accel_z);
            end
            MOP_B: begin
                mul_a = 40'(sr);
                mul_b = tanv;
            end
            MOP_C: begin
                mul_a = 40'(cr);
                mul_b = tanv;
            end
            MOP_BGY: begin
                mul_a = 40'(b_reg);
                mul_b = 25'(smp_reg.gyro_y);
            end
            MOP_CGZ: begin
                mul_a = 40'(c_reg);
                mul_b = 25'(smp_reg.gyro_z);
            end
            MOP_CRGY: begin
                mul_a = 40'(cr);
                mul_b = 25'(smp_reg.gyro_y);
            end
            MOP_SRGZ: begin
                mul_a = 40'(sr);
                mul_b = 25'(smp_reg.gyro_z);
            end
            MOP_DTR: begin
                mul_a = r24_r;
                mul_b = $signed({9'b0, smp_reg.interval});
            end
            MOP_DTP: begin
                mul_a = r24_p;
                mul_b = $signed({9'b0, smp_reg.interval});
            end
            MOP_AAR: begin
                mul_a = 40'(acc_r);
                mul_b = $signed({8'b0, alpha});
            end
            MOP_PRR: begin
                mul_a = predr_reg;
                mul_b = $signed({8'b0, one_minus});
            end
            MOP_AAP: begin
                mul_a = 40'(acc_p);
                mul_b = $signed({8'b0, alpha});
            end
            MOP_PRP: begin
                mul_a = predp_reg;
                mul_b = $signed({8'b0, one_minus});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (ph_reg && op_reg == MOP_AZZ) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: state_next = ST_CORD;
            ST_CORD: begin
                if (cnt_reg == 5'(STEPS - 1)) begin
                    state_next = ST_TCHK;
                end
            end
            ST_TCHK: state_next = tsat ? ST_MUL : ST_DIV;
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (ph_reg && op_reg == MOP_PRP) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        op_next = op_reg;
        ph_next = ph_reg;
        smp_next = smp_reg;
        ax2_next = ax2_reg;
        ay2_next = ay2_reg;
        sqv_next = sqv_reg;
        sqr_next = sqr_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        fold_next = fold_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        tneg_next = tneg_reg;
        b_next = b_reg;
        c_next = c_reg;
        rr_next = rr_reg;
        pr_next = pr_reg;
        predr_next = predr_reg;
        predp_next = predp_reg;
        mixr_next = mixr_reg;
        mixp_next = mixp_reg;
        prod_next = prod_reg;
        clip_next = clip_reg;
        roll_next = roll_reg;
        pitch_next = pitch_reg;
        m_valid_next = m_valid_reg && !m_ready;
        roll_out_next = roll_out_reg;
        pitch_out_next = pitch_out_reg;
        clip_out_next = clip_out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    smp_next = q_word;
                    clip_next = 1'b0;
                    op_next = MOP_AXX;
                    ph_next = 1'b0;
                end
            end
            ST_SQ, ST_MUL: begin
                ph_next = !ph_reg;
                if (!ph_reg) begin
                    prod_next = mul_a * mul_b;
                end else begin
                    if (op_reg != MOP_PRP) begin
                        op_next = mul_op_t'(op_reg + 4'd1);
                    end
                    case (op_reg)
                        MOP_AXX: ax2_next = prod_reg[31:0];
                        MOP_AYY: ay2_next = prod_reg[31:0];
                        MOP_AZZ: begin
                            sqv_next[0] = {ax2_reg + prod_reg[31:0], 16'b0};
                            sqv_next[1] = {ay2_reg + prod_reg[31:0], 16'b0};
                            sqr_next[0] = '0;
                            sqr_next[1] = '0;
                            cnt_next = '0;
                        end
                        MOP_B: b_next = prod_rnd[33:0];
                        MOP_C: c_next = prod_rnd[33:0];
                        MOP_BGY: begin
                            rr_next = {{12{smp_reg.gyro_x[15]}}, smp_reg.gyro_x, 24'b0}
                                + prod_reg[51:0];
                        end
                        MOP_CGZ: rr_next = rr_reg + prod_reg[51:0];
                        MOP_CRGY: pr_next = prod_reg[43:0];
                        MOP_SRGZ: pr_next = pr_reg - prod_reg[43:0];
                        MOP_DTR: predr_next = (40'(roll_reg) <<< SH) + prod_rnd[39:0];
                        MOP_DTP: predp_next = (40'(pitch_reg) <<< SH) + prod_rnd[39:0];
                        MOP_AAR: mixr_next = prod_reg[59:0];
                        MOP_PRR: mixr_next = mixr_reg + prod_reg[59:0];
                        MOP_AAP: mixp_next = prod_reg[59:0];
                        MOP_PRP: mixp_next = mixp_reg + prod_reg[59:0];
                        default: ;
                    endcase
                end
            end
            ST_SQRT: begin
                for (int l = 0; l < 2; l++) begin
                    if (sqv_reg[l] >= sqr_reg[l] + sq_bit) begin
                        sqv_next[l] = sqv_reg[l] - (sqr_reg[l] + sq_bit);
                        sqr_next[l] = (sqr_reg[l] >> 1) + sq_bit;
                    end else begin
                        sqr_next[l] = sqr_reg[l] >> 1;
                    end
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_CINIT: begin
                cx_next[0] = $signed({4'b0, sqr_reg[0][23:0]});
                cy_next[0] = CW'(smp_reg.accel_y) <<< 8;
                cz_next[0] = '0;
                cx_next[1] = $signed({4'b0, sqr_reg[1][23:0]});
                cy_next[1] = -(CW'(smp_reg.accel_x) <<< 8);
                cz_next[1] = '0;
                cx_next[2] = GAIN_INV;
                cy_next[2] = '0;
                cx_next[3] = GAIN_INV;
                cy_next[3] = '0;
                // Angles past a right angle are folded by pi and the results negated.
                if (th_r > HALF_PI_W) begin
                    cz_next[2] = th_r - PI_W;
                    fold_next[0] = 1'b1;
                end else if (th_r < -HALF_PI_W) begin
                    cz_next[2] = th_r + PI_W;
                    fold_next[0] = 1'b1;
                end else begin
                    cz_next[2] = th_r;
                    fold_next[0] = 1'b0;
                end
                if (th_p > HALF_PI_W) begin
                    cz_next[3] = th_p - PI_W;
                    fold_next[1] = 1'b1;
                end else if (th_p < -HALF_PI_W) begin
                    cz_next[3] = th_p + PI_W;
                    fold_next[1] = 1'b1;
                end else begin
                    cz_next[3] = th_p;
                    fold_next[1] = 1'b0;
                end
                cnt_next = '0;
            end
            ST_CORD: begin
                for (int l = 0; l < 2; l++) begin
                    if (!cy_reg[l][CW-1]) begin
                        cx_next[l] = cx_reg[l] + cdx[l];
                        cy_next[l] = cy_reg[l] - cdy[l];
                        cz_next[l] = cz_reg[l] + atan_entry(cnt_reg);
                    end else begin
                        cx_next[l] = cx_reg[l] - cdx[l];
                        cy_next[l] = cy_reg[l] + cdy[l];
                        cz_next[l] = cz_reg[l] - atan_entry(cnt_reg);
                    end
                end
                for (int l = 2; l < 4; l++) begin
                    if (!cz_reg[l][CW-1]) begin
                        cx_next[l] = cx_reg[l] - cdx[l];
                        cy_next[l] = cy_reg[l] + cdy[l];
                        cz_next[l] = cz_reg[l] - atan_entry(cnt_reg);
                    end else begin
                        cx_next[l] = cx_reg[l] + cdx[l];
                        cy_next[l] = cy_reg[l] - cdy[l];
                        cz_next[l] = cz_reg[l] + atan_entry(cnt_reg);
                    end
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_TCHK: begin
                tneg_next = tneg_c;
                div_next = ac_v;
                rem_next = {as_v, 16'b0};
                op_next = MOP_B;
                ph_next = 1'b0;
                cnt_next = DIV_TOP;
                if (tsat) begin
                    q_next = TAN_SAT_Q;
                    clip_next = 1'b1;
                end else begin
                    q_next = '0;
                end
            end
            ST_DIV: begin
                if ({6'b0, rem_reg} >= div_trial) begin
                    rem_next = rem_reg - div_trial[43:0];
                    q_next[cnt_reg] = 1'b1;
                end
                cnt_next = cnt_reg - 5'd1;
            end
            ST_SAT: begin
                if (ar > 44'(PI_F)) begin
                    roll_next = ANG_W'(PI_F);
                    clip_next = 1'b1;
                end else if (ar < -44'(PI_F)) begin
                    roll_next = -ANG_W'(PI_F);
                    clip_next = 1'b1;
                end else begin
                    roll_next = ar[ANG_W-1:0];
                end
                if (ap > 44'(PI_F)) begin
                    pitch_next = ANG_W'(PI_F);
                    clip_next = 1'b1;
                end else if (ap < -44'(PI_F)) begin
                    pitch_next = -ANG_W'(PI_F);
                    clip_next = 1'b1;
                end else begin
                    pitch_next = ap[ANG_W-1:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    roll_out_next = roll_ext[15:0];
                    pitch_out_next = pitch_ext[15:0];
                    clip_out_next = clip_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            roll_reg <= '0;
            pitch_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            roll_reg <= roll_next;
            pitch_reg <= pitch_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        op_reg <= op_next;
        ph_reg <= ph_next;
        smp_reg <= smp_next;
        ax2_reg <= ax2_next;
        ay2_reg <= ay2_next;
        sqv_reg <= sqv_next;
        sqr_reg <= sqr_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        fold_reg <= fold_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        tneg_reg <= tneg_next;
        b_reg <= b_next;
        c_reg <= c_next;
        rr_reg <= rr_next;
        pr_reg <= pr_next;
        predr_reg <= predr_next;
        predp_reg <= predp_next;
        mixr_reg <= mixr_next;
        mixp_reg <= mixp_next;
        prod_reg <= prod_next;
        clip_reg <= clip_next;
        roll_out_reg <= roll_out_next;
        pitch_out_reg <= pitch_out_next;
        clip_out_reg <= clip_out_next;
    end

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("Result word raised outside the completion step.");

    a_pop_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> state_reg == ST_SQ)
        else $error("Popped word did not start the square step.");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_reg != '0)
        else $error("Tangent division entered with a zero divisor.");

endmodule

// ===== hw/rtl/imu_complementary_attitude_filter.sv =====
// Channel   Direction  Handshake            Word
// s_*       in         s_valid / s_ready    gyro x/y/z, accel x/y/z, interval
// m_*       out        m_valid / m_ready    roll_out, pitch_out, clipped
// cfg_*     in         cfg_valid / cfg_ready  blend weight, Q1.16
//
// In the back end a sample passes the shared multiplier sequence, the square root
// iterations, the CORDIC steps and the tangent divider; the divider is skipped when
// the tangent saturates.
// Reset is synchronous and active low; it clears the angles and restores the weight.
// A two-word queue and a front register let samples arrive while the back end works.
// The result register holds its word until it is taken; a finished back end waits meanwhile.
module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = icaf_pkg::ANGLE_FRAC_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    input  logic signed [15:0] s_gyro_z,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic [15:0] s_interval,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [15:0] m_roll_out,
    output logic signed [15:0] m_pitch_out,
    output logic m_clipped,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [icaf_pkg::BLEND_W-1:0] cfg_data
);
    import icaf_pkg::*;

    logic [BLEND_W-1:0] blend_reg, blend_next;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    sample_t fq_word, qb_word;

    assign cfg_ready = 1'b1;

    always_comb begin
        blend_next = blend_reg;
        if (cfg_valid && cfg_ready) begin
            blend_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_reg <= BLEND_RESET;
        end else begin
            blend_reg <= blend_next;
        end
    end

    icaf_front u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_gyro_x(s_gyro_x),
        .s_gyro_y(s_gyro_y),
        .s_gyro_z(s_gyro_z),
        .s_accel_x(s_accel_x),
        .s_accel_y(s_accel_y),
        .s_accel_z(s_accel_z),
        .s_interval(s_interval),
        .q_valid(fq_valid),
        .q_ready(fq_ready),
        .q_word(fq_word)
    );

    icaf_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(fq_valid),
        .in_ready(fq_ready),
        .in_word(fq_word),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_word(qb_word)
    );

    icaf_back #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(qb_valid),
        .q_ready(qb_ready),
        .q_word(qb_word),
        .blend_weight(blend_reg),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_roll_out(m_roll_out),
        .m_pitch_out(m_pitch_out),
        .m_clipped(m_clipped)
    );

endmodule
